// ----- hw/rtl/psmc_pkg.sv -----
// ----------------------------------------------------------------------------
// psmc_pkg
// Shared types, widths and codes of the pump safety mode controller.
// ----------------------------------------------------------------------------
package psmc_pkg;

  // field widths
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned EPOCH_W     = 32;
  localparam int unsigned MINUTE_W    = 11;
  localparam int unsigned WAIT_W      = 16;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned IN_TUSER_W  = 3;
  localparam int unsigned MODE_CODE_W = 3;
  localparam int unsigned OUT_TDATA_W = 8;

  // queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  // input word layout
  localparam int unsigned TD_SAMPLE_LO = 0;
  localparam int unsigned TD_BUTTON_LO = 16;
  localparam int unsigned TD_DONE_BIT  = 18;
  localparam int unsigned TD_EPOCH_LO  = 19;
  localparam int unsigned TD_MINUTE_LO = 51;

  // request kinds on in_tuser
  localparam logic [IN_TUSER_W-1:0] REQ_BATT   = 3'd0;
  localparam logic [IN_TUSER_W-1:0] REQ_TANK   = 3'd1;
  localparam logic [IN_TUSER_W-1:0] REQ_RATE   = 3'd2;
  localparam logic [IN_TUSER_W-1:0] REQ_BUTTON = 3'd3;
  localparam logic [IN_TUSER_W-1:0] REQ_TICK   = 3'd4;

  // button codes
  localparam logic [1:0] KEY_MODE   = 2'd0;
  localparam logic [1:0] KEY_FORCE  = 2'd1;
  localparam logic [1:0] KEY_CONFIG = 2'd2;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_RATE     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_BATTERY  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_WIN_START    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_WIN_STOP     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_STARTUP_WAIT = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_AUTO_START   = 3'd5;

  // configuration reset values
  localparam logic [SAMPLE_W-1:0] RST_MIN_RATE     = 16'd0;
  localparam logic [SAMPLE_W-1:0] RST_MIN_BATTERY  = 16'd0;
  localparam logic [MINUTE_W-1:0] RST_WIN_START    = 11'd0;
  localparam logic [MINUTE_W-1:0] RST_WIN_STOP     = 11'd1439;
  localparam logic [WAIT_W-1:0]   RST_STARTUP_WAIT = 16'd120;

  // mode codes on the result word
  localparam logic [MODE_CODE_W-1:0] MODE_CODE_IDLE    = 3'd0;
  localparam logic [MODE_CODE_W-1:0] MODE_CODE_STARTUP = 3'd1;
  localparam logic [MODE_CODE_W-1:0] MODE_CODE_RUNNING = 3'd2;
  localparam logic [MODE_CODE_W-1:0] MODE_CODE_ERROR   = 3'd3;
  localparam logic [MODE_CODE_W-1:0] MODE_CODE_CONFIG  = 3'd4;

  // classified command kinds
  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_BATT   = 3'd1,
    CMD_RATE   = 3'd2,
    CMD_BUTTON = 3'd3,
    CMD_TICK   = 3'd4
  } cmd_kind_t;

  // classified button
  typedef enum logic [1:0] {
    BCLS_OTHER  = 2'd0,
    BCLS_FORCE  = 2'd1,
    BCLS_CONFIG = 2'd2
  } btn_cls_t;

  // one queued command
  typedef struct packed {
    cmd_kind_t             kind;
    btn_cls_t              btn;
    logic                  done;
    logic [SAMPLE_W-1:0]   sample;
    logic [EPOCH_W-1:0]    epoch;
    logic [MINUTE_W-1:0]   minute;
  } cmd_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // controller mode, one-hot
  typedef enum logic [4:0] {
    MODE_IDLE    = 5'b00001,
    MODE_STARTUP = 5'b00010,
    MODE_RUNNING = 5'b00100,
    MODE_ERROR   = 5'b01000,
    MODE_CONFIG  = 5'b10000
  } mode_t;

  // one-hot mode to result code
  function automatic logic [MODE_CODE_W-1:0] mode_code(input mode_t m);
    logic [MODE_CODE_W-1:0] c;
    c = MODE_CODE_IDLE;
    unique case (m)
      MODE_IDLE:    c = MODE_CODE_IDLE;
      MODE_STARTUP: c = MODE_CODE_STARTUP;
      MODE_RUNNING: c = MODE_CODE_RUNNING;
      MODE_ERROR:   c = MODE_CODE_ERROR;
      MODE_CONFIG:  c = MODE_CODE_CONFIG;
      default:      c = MODE_CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/psmc_front.sv -----
// ----------------------------------------------------------------------------
// psmc_front
// Accepts input words, classifies event kind and button, pushes commands.
// ----------------------------------------------------------------------------
module psmc_front (
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [psmc_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic [psmc_pkg::IN_TUSER_W-1:0]   in_tuser,
  input  psmc_pkg::q_status_t               q_status,
  output logic                              push,
  output psmc_pkg::cmd_t                    push_cmd
);

  psmc_pkg::cmd_kind_t kind;
  psmc_pkg::btn_cls_t  btn;
  logic [1:0]          button_code;

  assign button_code = in_tdata[psmc_pkg::TD_BUTTON_LO +: 2];

  // event kind; tank samples and unknown kinds change nothing
  always_comb begin
    unique case (in_tuser)
      psmc_pkg::REQ_BATT:   kind = psmc_pkg::CMD_BATT;
      psmc_pkg::REQ_RATE:   kind = psmc_pkg::CMD_RATE;
      psmc_pkg::REQ_BUTTON: kind = psmc_pkg::CMD_BUTTON;
      psmc_pkg::REQ_TICK:   kind = psmc_pkg::CMD_TICK;
      default:              kind = psmc_pkg::CMD_NONE;
    endcase
  end

  // button class; mode button and unused code act alike
  always_comb begin
    unique case (button_code)
      psmc_pkg::KEY_FORCE:  btn = psmc_pkg::BCLS_FORCE;
      psmc_pkg::KEY_CONFIG: btn = psmc_pkg::BCLS_CONFIG;
      default:              btn = psmc_pkg::BCLS_OTHER;
    endcase
  end

  // command assembly
  always_comb begin
    push_cmd.kind   = kind;
    push_cmd.btn    = btn;
    push_cmd.done   = in_tdata[psmc_pkg::TD_DONE_BIT];
    push_cmd.sample = in_tdata[psmc_pkg::TD_SAMPLE_LO +: psmc_pkg::SAMPLE_W];
    push_cmd.epoch  = in_tdata[psmc_pkg::TD_EPOCH_LO +: psmc_pkg::EPOCH_W];
    push_cmd.minute = in_tdata[psmc_pkg::TD_MINUTE_LO +: psmc_pkg::MINUTE_W];
  end

  assign in_tready = !q_status.full;
  assign push      = in_tvalid && in_tready;

endmodule

// ----- hw/rtl/psmc_queue.sv -----
// ----------------------------------------------------------------------------
// psmc_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module psmc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  psmc_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output psmc_pkg::cmd_t      head_cmd,
  output psmc_pkg::q_status_t q_status
);

  psmc_pkg::cmd_t                 entry_r [psmc_pkg::Q_DEPTH];
  logic [psmc_pkg::Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [psmc_pkg::Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [psmc_pkg::Q_CNT_W-1:0]   count_r, count_nxt;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head_cmd       = entry_r[rd_ptr_r];
  assign q_status.full  = (count_r == psmc_pkg::Q_CNT_W'(psmc_pkg::Q_DEPTH));
  assign q_status.empty = (count_r == '0);

  // fill count stays within depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= psmc_pkg::Q_CNT_W'(psmc_pkg::Q_DEPTH))
    else $error("queue count beyond depth");

  // nothing is popped from an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_status.empty |-> !pop)
    else $error("pop from empty queue");

endmodule

// ----- hw/rtl/psmc_back.sv -----
// ----------------------------------------------------------------------------
// psmc_back
// Executes queued commands on the mode state and registers each result word.
// ----------------------------------------------------------------------------
module psmc_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  psmc_pkg::q_status_t                q_status,
  input  psmc_pkg::cmd_t                     head_cmd,
  output logic                               pop,
  input  logic                               cfg_wr,
  input  logic [psmc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [psmc_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [psmc_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  // configuration registers
  logic [psmc_pkg::SAMPLE_W-1:0] min_rate_r;
  logic [psmc_pkg::SAMPLE_W-1:0] min_batt_r;
  logic [psmc_pkg::MINUTE_W-1:0] win_start_r;
  logic [psmc_pkg::MINUTE_W-1:0] win_stop_r;
  logic [psmc_pkg::WAIT_W-1:0]   wait_r;
  logic                          auto_start_r;

  // controller state
  psmc_pkg::mode_t               mode_r, mode_nxt;
  logic                          bypass_r, bypass_nxt;
  logic                          pump_r, pump_nxt;
  logic                          fault_r, fault_nxt;
  logic [psmc_pkg::SAMPLE_W-1:0] batt_r, batt_nxt;
  logic [psmc_pkg::SAMPLE_W-1:0] rate_r, rate_nxt;
  logic [psmc_pkg::EPOCH_W-1:0]  begin_r, begin_nxt;

  // output register
  logic                                 out_valid_r;
  logic [psmc_pkg::OUT_TDATA_W-1:0]     out_data_r, out_data_nxt;

  // checks
  logic                          batt_raw, rate_raw, win_raw;
  logic                          batt_ok, rate_ok, win_ok;
  logic [psmc_pkg::EPOCH_W-1:0]  elapsed;
  logic                          wait_over;

  assign pop = !q_status.empty && (!out_valid_r || out_tready);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_rate_r   <= psmc_pkg::RST_MIN_RATE;
      min_batt_r   <= psmc_pkg::RST_MIN_BATTERY;
      win_start_r  <= psmc_pkg::RST_WIN_START;
      win_stop_r   <= psmc_pkg::RST_WIN_STOP;
      wait_r       <= psmc_pkg::RST_STARTUP_WAIT;
      auto_start_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_addr)
        psmc_pkg::CFG_MIN_RATE:     min_rate_r   <= cfg_data;
        psmc_pkg::CFG_MIN_BATTERY:  min_batt_r   <= cfg_data;
        psmc_pkg::CFG_WIN_START:    win_start_r  <= cfg_data[psmc_pkg::MINUTE_W-1:0];
        psmc_pkg::CFG_WIN_STOP:     win_stop_r   <= cfg_data[psmc_pkg::MINUTE_W-1:0];
        psmc_pkg::CFG_STARTUP_WAIT: wait_r       <= cfg_data;
        psmc_pkg::CFG_AUTO_START:   auto_start_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // strict threshold checks
  assign batt_raw  = batt_r > min_batt_r;
  assign rate_raw  = rate_r > min_rate_r;
  assign win_raw   = (head_cmd.minute > win_start_r) && (head_cmd.minute < win_stop_r);
  assign batt_ok   = batt_raw || bypass_r;
  assign rate_ok   = rate_raw || bypass_r;
  assign win_ok    = win_raw || bypass_r;
  assign elapsed   = head_cmd.epoch - begin_r;
  assign wait_over = (head_cmd.epoch > begin_r) &&
                     (elapsed > psmc_pkg::EPOCH_W'(wait_r));

  // command execution
  always_comb begin
    mode_nxt   = mode_r;
    bypass_nxt = bypass_r;
    pump_nxt   = pump_r;
    fault_nxt  = fault_r;
    batt_nxt   = batt_r;
    rate_nxt   = rate_r;
    begin_nxt  = begin_r;
    unique case (head_cmd.kind)
      psmc_pkg::CMD_BATT: batt_nxt = head_cmd.sample;
      psmc_pkg::CMD_RATE: rate_nxt = head_cmd.sample;
      psmc_pkg::CMD_BUTTON: begin
        unique case (mode_r)
          psmc_pkg::MODE_IDLE: begin
            if (head_cmd.btn == psmc_pkg::BCLS_FORCE) begin
              bypass_nxt = 1'b1;
              mode_nxt   = psmc_pkg::MODE_RUNNING;
            end else if (head_cmd.btn == psmc_pkg::BCLS_CONFIG) begin
              mode_nxt = psmc_pkg::MODE_CONFIG;
            end
          end
          psmc_pkg::MODE_STARTUP: begin
            if (head_cmd.btn == psmc_pkg::BCLS_FORCE) begin
              mode_nxt   = psmc_pkg::MODE_IDLE;
              bypass_nxt = 1'b0;
            end
          end
          psmc_pkg::MODE_RUNNING: begin
            if (head_cmd.btn == psmc_pkg::BCLS_FORCE) begin
              pump_nxt = 1'b0;
              mode_nxt = psmc_pkg::MODE_IDLE;
            end
          end
          psmc_pkg::MODE_ERROR: begin
            if (head_cmd.btn == psmc_pkg::BCLS_FORCE) begin
              mode_nxt = psmc_pkg::MODE_IDLE;
            end
          end
          psmc_pkg::MODE_CONFIG: begin
            if (head_cmd.done) begin
              mode_nxt = psmc_pkg::MODE_IDLE;
            end
          end
          default: ;
        endcase
      end
      psmc_pkg::CMD_TICK: begin
        unique case (mode_r)
          psmc_pkg::MODE_IDLE: begin
            // bypass is cleared before the checks are taken
            bypass_nxt = 1'b0;
            fault_nxt  = 1'b0;
            if (batt_raw && win_raw && auto_start_r) begin
              pump_nxt = 1'b1;
              mode_nxt = psmc_pkg::MODE_STARTUP;
            end else begin
              pump_nxt = 1'b0;
            end
          end
          psmc_pkg::MODE_STARTUP: begin
            if (begin_r == '0) begin
              begin_nxt = head_cmd.epoch;
            end else if (wait_over) begin
              begin_nxt = '0;
              if (rate_ok) begin
                mode_nxt = (batt_ok && win_ok) ? psmc_pkg::MODE_RUNNING
                                               : psmc_pkg::MODE_IDLE;
              end else begin
                mode_nxt  = psmc_pkg::MODE_ERROR;
                fault_nxt = 1'b1;
              end
            end
          end
          psmc_pkg::MODE_RUNNING: begin
            if (rate_ok) begin
              if ((batt_ok && win_ok) || bypass_r) begin
                pump_nxt = 1'b1;
              end else begin
                mode_nxt = psmc_pkg::MODE_IDLE;
                pump_nxt = 1'b0;
              end
            end else begin
              pump_nxt  = 1'b0;
              mode_nxt  = psmc_pkg::MODE_ERROR;
              fault_nxt = 1'b1;
            end
          end
          psmc_pkg::MODE_ERROR: begin
            pump_nxt   = 1'b0;
            bypass_nxt = 1'b0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // result word: mode, pump, fault from the lowest bit up
  always_comb begin
    out_data_nxt = {{(psmc_pkg::OUT_TDATA_W - psmc_pkg::MODE_CODE_W - 2){1'b0}},
                    fault_nxt, pump_nxt, psmc_pkg::mode_code(mode_nxt)};
  end

  // state update on pop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= psmc_pkg::MODE_IDLE;
      bypass_r <= 1'b0;
      pump_r   <= 1'b0;
      fault_r  <= 1'b0;
      batt_r   <= '0;
      rate_r   <= '0;
      begin_r  <= '0;
    end else if (pop) begin
      mode_r   <= mode_nxt;
      bypass_r <= bypass_nxt;
      pump_r   <= pump_nxt;
      fault_r  <= fault_nxt;
      batt_r   <= batt_nxt;
      rate_r   <= rate_nxt;
      begin_r  <= begin_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // error mode always carries the fault flag
  a_error_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == psmc_pkg::MODE_ERROR) |-> fault_r)
    else $error("error mode without fault flag");

  // startup is only entered from an idle tick that clears bypass
  a_startup_no_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == psmc_pkg::MODE_STARTUP) |-> !bypass_r)
    else $error("bypass set during startup wait");

  // every executed command shows up as a result word
  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid_r)
    else $error("executed command without result word");

endmodule

// ----- hw/rtl/pump_safety_mode_controller_top.sv -----
// ----------------------------------------------------------------------------
// pump_safety_mode_controller_top
// Pump safety mode controller: event stream in, one status word out per event.
// ----------------------------------------------------------------------------
// One event word is taken per clock while the queue has room; each returns
// exactly one status word (mode, pump drive, fault). The front stage
// classifies the event, a two-entry queue holds it, and the back stage applies
// it to the mode state while loading the output register, one event per cycle
// while out_tready is high; the output register and the queue absorb stalls
// on out_tready. Configuration writes are always ready and take effect on the
// next cycle; they must be made while no event is in flight (not enforced).
module pump_safety_mode_controller_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // event channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // sample_value, button_code, menu_done, epoch_seconds, minute_of_day, pad
  input  logic [psmc_pkg::IN_TDATA_W-1:0]   in_tdata,
  // req_type
  input  logic [psmc_pkg::IN_TUSER_W-1:0]   in_tuser,
  // status channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // mode, pump_on, fault_code, pad
  output logic [psmc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [psmc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [psmc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  psmc_pkg::q_status_t q_status;
  psmc_pkg::cmd_t      push_cmd;
  psmc_pkg::cmd_t      head_cmd;
  logic                push;
  logic                pop;
  logic                cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  psmc_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_status  (q_status),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  psmc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_status (q_status)
  );

  psmc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_status   (q_status),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .cfg_wr     (cfg_wr),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- sim/tb_pump_safety_mode_controller_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pump_safety_mode_controller_top
// Self-checking bench for the pump safety mode controller.
// ----------------------------------------------------------------------------
// Event words go in on the input stream and one status word per event comes
// back. A behavioral copy of the controller predicts each status word when its
// event is accepted, and a checker compares every returned word against the
// oldest prediction. Directed mode paths come first, then random event streams
// under several threshold and window settings, with random gaps and back
// pressure and a final stretch at full rate.
// ----------------------------------------------------------------------------
module tb_pump_safety_mode_controller_top;

  // request and button codes outside the defined set
  localparam logic [psmc_pkg::IN_TUSER_W-1:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [psmc_pkg::IN_TUSER_W-1:0] REQ_UNUSED_HI = 3'd7;
  localparam logic [1:0]                      KEY_SPARE     = 2'd3;

  localparam int          MINUTE_MAX   = 1439;
  localparam int          SAMPLE_MAX   = 65535;
  localparam int unsigned IDLE_LIMIT   = 1000;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned BURST_ITEMS  = 290;
  localparam int unsigned FINAL_ITEMS  = 210;

  localparam logic [psmc_pkg::MINUTE_W-1:0] LAST_MINUTE = 11'd1439;

  // one status word split into its fields
  typedef struct packed {
    logic [psmc_pkg::MODE_CODE_W-1:0] mode;
    logic                             pump_on;
    logic                             fault;
  } status_t;

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [psmc_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic [psmc_pkg::IN_TUSER_W-1:0]  in_tuser;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [psmc_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [psmc_pkg::CFG_ADDR_W-1:0]  cfg_addr;
  logic [psmc_pkg::CFG_DATA_W-1:0]  cfg_data;

  // controller copy: mode state
  logic [psmc_pkg::MODE_CODE_W-1:0] ctl_mode     = psmc_pkg::MODE_CODE_IDLE;
  logic                             ctl_bypass   = 1'b0;
  logic                             ctl_pump     = 1'b0;
  logic                             ctl_fault    = 1'b0;
  logic [psmc_pkg::SAMPLE_W-1:0]    last_battery = '0;
  logic [psmc_pkg::SAMPLE_W-1:0]    last_rate    = '0;
  logic [psmc_pkg::EPOCH_W-1:0]     start_epoch  = '0;

  // controller copy: thresholds and window
  logic [psmc_pkg::SAMPLE_W-1:0]    thr_rate     = psmc_pkg::RST_MIN_RATE;
  logic [psmc_pkg::SAMPLE_W-1:0]    thr_battery  = psmc_pkg::RST_MIN_BATTERY;
  logic [psmc_pkg::MINUTE_W-1:0]    win_lo       = psmc_pkg::RST_WIN_START;
  logic [psmc_pkg::MINUTE_W-1:0]    win_hi       = psmc_pkg::RST_WIN_STOP;
  logic [psmc_pkg::WAIT_W-1:0]      wait_secs    = psmc_pkg::RST_STARTUP_WAIT;
  logic                             auto_en      = 1'b0;

  status_t                          pending_status[$];
  int unsigned                      items_sent      = 0;
  int unsigned                      results_checked = 0;
  int unsigned                      mismatch_count  = 0;
  int unsigned                      phases_run      = 0;
  bit                               sender_gaps     = 1'b1;
  bit                               sink_stalls     = 1'b1;
  logic [psmc_pkg::EPOCH_W-1:0]     sim_epoch       = '0;

  pump_safety_mode_controller_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // strict checks, all overridden by the bypass flag
  function automatic logic battery_good();
    return (last_battery > thr_battery) || ctl_bypass;
  endfunction

  function automatic logic rate_good();
    return (last_rate > thr_rate) || ctl_bypass;
  endfunction

  function automatic logic window_good(input logic [psmc_pkg::MINUTE_W-1:0] minute);
    return ((minute > win_lo) && (minute < win_hi)) || ctl_bypass;
  endfunction

  // register value from a plain number
  function automatic logic [psmc_pkg::CFG_DATA_W-1:0] cfg_val(input int unsigned v);
    return v[psmc_pkg::CFG_DATA_W-1:0];
  endfunction

  // apply one event to the controller copy and return the status after it
  function automatic status_t apply_event(input logic [psmc_pkg::IN_TUSER_W-1:0] kind,
                                          input logic [psmc_pkg::IN_TDATA_W-1:0] word);
    logic [psmc_pkg::SAMPLE_W-1:0] sample;
    logic [1:0]                    btn;
    logic                          done;
    logic [psmc_pkg::EPOCH_W-1:0]  now;
    logic [psmc_pkg::MINUTE_W-1:0] minute;
    status_t                       st;
    sample = word[psmc_pkg::TD_SAMPLE_LO +: psmc_pkg::SAMPLE_W];
    btn    = word[psmc_pkg::TD_BUTTON_LO +: 2];
    done   = word[psmc_pkg::TD_DONE_BIT];
    now    = word[psmc_pkg::TD_EPOCH_LO +: psmc_pkg::EPOCH_W];
    minute = word[psmc_pkg::TD_MINUTE_LO +: psmc_pkg::MINUTE_W];
    unique case (kind)
      psmc_pkg::REQ_BATT: last_battery = sample;
      psmc_pkg::REQ_RATE: last_rate = sample;
      psmc_pkg::REQ_BUTTON: begin
        unique case (ctl_mode)
          psmc_pkg::MODE_CODE_IDLE: begin
            if (btn == psmc_pkg::KEY_FORCE) begin
              ctl_bypass = 1'b1;
              ctl_mode   = psmc_pkg::MODE_CODE_RUNNING;
            end else if (btn == psmc_pkg::KEY_CONFIG) begin
              ctl_mode = psmc_pkg::MODE_CODE_CONFIG;
            end
          end
          psmc_pkg::MODE_CODE_STARTUP: begin
            // force stop keeps the pump drive and the begin time
            if (btn == psmc_pkg::KEY_FORCE) begin
              ctl_mode   = psmc_pkg::MODE_CODE_IDLE;
              ctl_bypass = 1'b0;
            end
          end
          psmc_pkg::MODE_CODE_RUNNING: begin
            if (btn == psmc_pkg::KEY_FORCE) begin
              ctl_pump = 1'b0;
              ctl_mode = psmc_pkg::MODE_CODE_IDLE;
            end
          end
          psmc_pkg::MODE_CODE_ERROR: begin
            if (btn == psmc_pkg::KEY_FORCE) ctl_mode = psmc_pkg::MODE_CODE_IDLE;
          end
          psmc_pkg::MODE_CODE_CONFIG: begin
            if (done) ctl_mode = psmc_pkg::MODE_CODE_IDLE;
          end
          default: ;
        endcase
      end
      psmc_pkg::REQ_TICK: begin
        unique case (ctl_mode)
          psmc_pkg::MODE_CODE_IDLE: begin
            ctl_bypass = 1'b0;
            ctl_fault  = 1'b0;
            if (battery_good() && window_good(minute) && auto_en) begin
              ctl_pump = 1'b1;
              ctl_mode = psmc_pkg::MODE_CODE_STARTUP;
            end else begin
              ctl_pump = 1'b0;
            end
          end
          psmc_pkg::MODE_CODE_STARTUP: begin
            // zero begin time means not yet recorded
            if (start_epoch == '0) begin
              start_epoch = now;
            end else if ((now > start_epoch) && ((now - start_epoch) > wait_secs)) begin
              start_epoch = '0;
              if (rate_good()) begin
                ctl_mode = (battery_good() && window_good(minute)) ?
                           psmc_pkg::MODE_CODE_RUNNING : psmc_pkg::MODE_CODE_IDLE;
              end else begin
                ctl_mode  = psmc_pkg::MODE_CODE_ERROR;
                ctl_fault = 1'b1;
              end
            end
          end
          psmc_pkg::MODE_CODE_RUNNING: begin
            if (rate_good()) begin
              if ((battery_good() && window_good(minute)) || ctl_bypass) begin
                ctl_pump = 1'b1;
              end else begin
                ctl_mode = psmc_pkg::MODE_CODE_IDLE;
                ctl_pump = 1'b0;
              end
            end else begin
              ctl_pump  = 1'b0;
              ctl_mode  = psmc_pkg::MODE_CODE_ERROR;
              ctl_fault = 1'b1;
            end
          end
          psmc_pkg::MODE_CODE_ERROR: begin
            ctl_pump   = 1'b0;
            ctl_bypass = 1'b0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    st.mode    = ctl_mode;
    st.pump_on = ctl_pump;
    st.fault   = ctl_fault;
    return st;
  endfunction

  // pack the event fields into the input word
  function automatic logic [psmc_pkg::IN_TDATA_W-1:0] build_word(
      input logic [psmc_pkg::SAMPLE_W-1:0] sample,
      input logic [1:0]                    btn,
      input logic                          done,
      input logic [psmc_pkg::EPOCH_W-1:0]  now,
      input logic [psmc_pkg::MINUTE_W-1:0] minute);
    logic [psmc_pkg::IN_TDATA_W-1:0] w;
    w = '0;
    w[psmc_pkg::TD_SAMPLE_LO +: psmc_pkg::SAMPLE_W] = sample;
    w[psmc_pkg::TD_BUTTON_LO +: 2]                  = btn;
    w[psmc_pkg::TD_DONE_BIT]                        = done;
    w[psmc_pkg::TD_EPOCH_LO +: psmc_pkg::EPOCH_W]   = now;
    w[psmc_pkg::TD_MINUTE_LO +: psmc_pkg::MINUTE_W] = minute;
    return w;
  endfunction

  // sample value near a threshold, or anywhere
  function automatic logic [psmc_pkg::SAMPLE_W-1:0] near_threshold(
      input logic [psmc_pkg::SAMPLE_W-1:0] thr);
    int v;
    if ($urandom_range(0, 4) < 2) return psmc_pkg::SAMPLE_W'($urandom);
    v = int'(thr) + int'($urandom_range(0, 2)) - 1;
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return v[psmc_pkg::SAMPLE_W-1:0];
  endfunction

  function automatic logic [psmc_pkg::MINUTE_W-1:0] clamp_minute(input int v);
    if (v < 0) return '0;
    if (v > MINUTE_MAX) return LAST_MINUTE;
    return v[psmc_pkg::MINUTE_W-1:0];
  endfunction

  // send one event word, predict its status once accepted
  task automatic send_event(input logic [psmc_pkg::IN_TUSER_W-1:0] kind,
                            input logic [psmc_pkg::IN_TDATA_W-1:0] word);
    int unsigned gap;
    if (sender_gaps && ($urandom_range(0, 3) == 0)) begin
      gap = $urandom_range(1, 7);
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser  = kind;
    in_tdata  = word;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_status.push_back(apply_event(kind, word));
    items_sent++;
    @(negedge clk);
  endtask

  // hold the input until every predicted status word is back
  task automatic wait_for_results();
    in_tvalid = 1'b0;
    while (pending_status.size() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [psmc_pkg::CFG_ADDR_W-1:0] index,
                           input logic [psmc_pkg::CFG_DATA_W-1:0] value);
    cfg_addr  = index;
    cfg_data  = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    unique case (index)
      psmc_pkg::CFG_MIN_RATE:     thr_rate    = value;
      psmc_pkg::CFG_MIN_BATTERY:  thr_battery = value;
      psmc_pkg::CFG_WIN_START:    win_lo      = value[psmc_pkg::MINUTE_W-1:0];
      psmc_pkg::CFG_WIN_STOP:     win_hi      = value[psmc_pkg::MINUTE_W-1:0];
      psmc_pkg::CFG_STARTUP_WAIT: wait_secs   = value;
      psmc_pkg::CFG_AUTO_START:   auto_en     = value[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // write all registers while nothing is in flight
  task automatic apply_settings(input logic [psmc_pkg::CFG_DATA_W-1:0] rate_min,
                                input logic [psmc_pkg::CFG_DATA_W-1:0] batt_min,
                                input logic [psmc_pkg::CFG_DATA_W-1:0] win_first,
                                input logic [psmc_pkg::CFG_DATA_W-1:0] win_last,
                                input logic [psmc_pkg::CFG_DATA_W-1:0] wait_len,
                                input logic                            auto_start);
    wait_for_results();
    cfg_write(psmc_pkg::CFG_MIN_RATE, rate_min);
    cfg_write(psmc_pkg::CFG_MIN_BATTERY, batt_min);
    cfg_write(psmc_pkg::CFG_WIN_START, win_first);
    cfg_write(psmc_pkg::CFG_WIN_STOP, win_last);
    cfg_write(psmc_pkg::CFG_STARTUP_WAIT, wait_len);
    cfg_write(psmc_pkg::CFG_AUTO_START, {{(psmc_pkg::CFG_DATA_W-1){1'b0}}, auto_start});
    cfg_valid = 1'b0;
    phases_run++;
  endtask

  // random event: half are ticks, mostly with advancing time; samples near thresholds
  task automatic send_random_event();
    int unsigned                     pick;
    int unsigned                     sel;
    logic [psmc_pkg::IN_TUSER_W-1:0] kind;
    logic [psmc_pkg::SAMPLE_W-1:0]   sample;
    logic [1:0]                      btn;
    logic                            done;
    logic [psmc_pkg::EPOCH_W-1:0]    now;
    logic [psmc_pkg::MINUTE_W-1:0]   minute;
    sample = psmc_pkg::SAMPLE_W'($urandom);
    btn    = 2'($urandom);
    done   = 1'($urandom);
    now    = $urandom;
    minute = psmc_pkg::MINUTE_W'($urandom_range(0, MINUTE_MAX));
    pick   = $urandom_range(0, 99);
    if (pick < 50) begin
      kind = psmc_pkg::REQ_TICK;
      sel  = $urandom_range(0, 19);
      unique case (sel)
        0:       sim_epoch = $urandom;
        1:       sim_epoch = '0;
        2:       sim_epoch = sim_epoch - $urandom_range(1, 50);
        3:       sim_epoch = {psmc_pkg::EPOCH_W{1'b1}} - $urandom_range(0, 100);
        default: sim_epoch = sim_epoch + $urandom_range(0, wait_secs / 8 + 8);
      endcase
      now = sim_epoch;
      sel = $urandom_range(0, 3);
      unique case (sel)
        1: minute = clamp_minute(int'(win_lo) + int'($urandom_range(0, 2)) - 1);
        2: minute = clamp_minute(int'(win_hi) + int'($urandom_range(0, 2)) - 1);
        3: if (win_hi > win_lo + 1)
             minute = psmc_pkg::MINUTE_W'($urandom_range(win_lo + 1, win_hi - 1));
        default: ;
      endcase
    end else if (pick < 65) begin
      kind   = psmc_pkg::REQ_BATT;
      sample = near_threshold(thr_battery);
    end else if (pick < 80) begin
      kind   = psmc_pkg::REQ_RATE;
      sample = near_threshold(thr_rate);
    end else if (pick < 86) begin
      kind = psmc_pkg::REQ_TANK;
    end else if (pick < 95) begin
      kind = psmc_pkg::REQ_BUTTON;
    end else begin
      kind = psmc_pkg::IN_TUSER_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
    end
    send_event(kind, build_word(sample, btn, done, now, minute));
  endtask

  task automatic send_random_burst(input int unsigned count);
    repeat (count) send_random_event();
  endtask

  // ignored events, config mode and the forced start/stop with reset settings
  task automatic test_directed_events();
    send_event(psmc_pkg::REQ_TICK, build_word('0, psmc_pkg::KEY_MODE, 1'b0, '0, '0));
    send_event(psmc_pkg::REQ_TANK, build_word('1, psmc_pkg::KEY_MODE, 1'b0, '0, '0));
    send_event(REQ_UNUSED_HI, '1);
    send_event(psmc_pkg::REQ_BATT, build_word('1, psmc_pkg::KEY_MODE, 1'b0, '0, '0));
    send_event(psmc_pkg::REQ_RATE, build_word('1, psmc_pkg::KEY_MODE, 1'b0, '0, '0));
    send_event(psmc_pkg::REQ_BUTTON, build_word('0, psmc_pkg::KEY_MODE, 1'b1, '0, '0));
    send_event(psmc_pkg::REQ_BUTTON, build_word('0, KEY_SPARE, 1'b1, '0, '0));
    send_event(psmc_pkg::REQ_BUTTON, build_word('0, psmc_pkg::KEY_CONFIG, 1'b0, '0, '0));
    // ticks and unfinished menus do nothing in config mode
    send_event(psmc_pkg::REQ_TICK,
               build_word('0, psmc_pkg::KEY_MODE, 1'b0, '1, LAST_MINUTE));
    send_event(psmc_pkg::REQ_BUTTON, build_word('0, psmc_pkg::KEY_FORCE, 1'b0, '0, '0));
    send_event(psmc_pkg::REQ_BUTTON, build_word('0, psmc_pkg::KEY_MODE, 1'b1, '0, '0));
    // forced start, pump follows on the next tick
    send_event(psmc_pkg::REQ_BUTTON, build_word('0, psmc_pkg::KEY_FORCE, 1'b0, '0, '0));
    send_event(psmc_pkg::REQ_TICK,
               build_word('0, psmc_pkg::KEY_MODE, 1'b0, 32'd5, 11'd100));
    send_event(psmc_pkg::REQ_BUTTON, build_word('0, psmc_pkg::KEY_FORCE, 1'b0, '0, '0));
    send_event(psmc_pkg::REQ_TICK,
               build_word('0, psmc_pkg::KEY_MODE, 1'b0, 32'd6, 11'd100));
  endtask

  // tick at a given epoch and minute
  task automatic send_tick(input logic [psmc_pkg::EPOCH_W-1:0]  now,
                           input logic [psmc_pkg::MINUTE_W-1:0] minute);
    send_event(psmc_pkg::REQ_TICK, build_word('0, psmc_pkg::KEY_MODE, 1'b0, now, minute));
  endtask

  // automatic start, startup wait timing, rate fault and recovery
  task automatic test_startup_sequence();
    apply_settings(psmc_pkg::RST_MIN_RATE, psmc_pkg::RST_MIN_BATTERY,
                   cfg_val(psmc_pkg::RST_WIN_START), cfg_val(psmc_pkg::RST_WIN_STOP),
                   psmc_pkg::RST_STARTUP_WAIT, 1'b1);
    send_tick('0, 11'd100);
    // zero epoch leaves the begin time unrecorded
    send_tick('0, 11'd100);
    send_tick(32'd1000, 11'd100);
    // earlier epoch, then exactly the wait length: not elapsed
    send_tick(32'd500, 11'd100);
    send_tick(32'd1120, 11'd100);
    send_event(psmc_pkg::REQ_RATE, build_word('0, psmc_pkg::KEY_MODE, 1'b0, '0, '0));
    send_tick(32'd1121, 11'd100);
    send_tick(32'd1122, 11'd100);
    send_event(psmc_pkg::REQ_BUTTON, build_word('0, psmc_pkg::KEY_FORCE, 1'b0, '0, '0));
    // idle tick clears the fault and restarts
    send_tick(32'd2000, 11'd100);
    send_event(psmc_pkg::REQ_BUTTON, build_word('0, psmc_pkg::KEY_FORCE, 1'b0, '0, '0));
    send_event(psmc_pkg::REQ_RATE, build_word('1, psmc_pkg::KEY_MODE, 1'b0, '0, '0));
    send_tick(32'd3000, 11'd100);
    send_tick(32'd3200, 11'd100);
    // a tick at the window edge while the startup wait runs changes nothing
    send_tick(32'd3201, LAST_MINUTE);
  endtask

  task automatic test_threshold_extremes();
    apply_settings('1, '1, cfg_val(MINUTE_MAX), '0, '1, 1'b1);
    send_random_burst(BURST_ITEMS);
    apply_settings('0, '0, '0, cfg_val(MINUTE_MAX), '0, 1'b1);
    send_random_burst(BURST_ITEMS);
  endtask

  task automatic test_random_settings();
    logic [psmc_pkg::CFG_DATA_W-1:0] rate_min;
    logic [psmc_pkg::CFG_DATA_W-1:0] batt_min;
    logic [psmc_pkg::CFG_DATA_W-1:0] win_first;
    logic [psmc_pkg::CFG_DATA_W-1:0] win_last;
    repeat (4) begin
      rate_min  = ($urandom_range(0, 3) == 0) ? cfg_val($urandom)
                                              : cfg_val($urandom_range(0, 200));
      batt_min  = ($urandom_range(0, 3) == 0) ? cfg_val($urandom)
                                              : cfg_val($urandom_range(0, 200));
      win_first = cfg_val($urandom_range(0, 720));
      win_last  = cfg_val($urandom_range(win_first, MINUTE_MAX));
      apply_settings(rate_min, batt_min, win_first, win_last,
                     cfg_val($urandom_range(0, 40)), $urandom_range(0, 3) != 0);
      send_random_burst(BURST_ITEMS);
    end
  endtask

  // full rate on both sides
  task automatic test_no_idle_stretch();
    apply_settings(cfg_val($urandom_range(0, 100)), cfg_val($urandom_range(0, 100)),
                   cfg_val($urandom_range(0, 60)), cfg_val($urandom_range(1380, MINUTE_MAX)),
                   16'd5, 1'b1);
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    send_random_burst(FINAL_ITEMS);
  endtask

  // result side back pressure in random bursts
  initial begin : sink_ctrl
    int unsigned burst;
    burst      = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (burst != 0) begin
        out_tready = 1'b0;
        burst--;
      end else if (sink_stalls && ($urandom_range(0, 4) == 0)) begin
        burst      = $urandom_range(1, 7) - 1;
        out_tready = 1'b0;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // compare each status word with the oldest prediction
  always @(posedge clk) begin : check_status
    status_t got;
    status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.mode    = out_tdata[psmc_pkg::MODE_CODE_W-1:0];
      got.pump_on = out_tdata[psmc_pkg::MODE_CODE_W];
      got.fault   = out_tdata[psmc_pkg::MODE_CODE_W+1];
      results_checked++;
      if (pending_status.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("[%0t] unexpected status word 0x%02h", $realtime, out_tdata);
      end else begin
        want = pending_status.pop_front();
        if ((got.mode !== want.mode) || (got.pump_on !== want.pump_on) ||
            (got.fault !== want.fault)) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] word %0d exp/got: mode %0d/%0d pump %0b/%0b fault %0b/%0b",
                     $realtime, results_checked, want.mode, got.mode, want.pump_on,
                     got.pump_on, want.fault, got.fault);
        end
      end
    end
  end

  // end the run if no word moves on any channel for too long
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[%0t] no progress for %0d cycles", $realtime, IDLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // main sequence
  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_valid = 1'b0;
    cfg_addr  = '0;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_events();
    test_startup_sequence();
    test_threshold_extremes();
    test_random_settings();
    test_no_idle_stretch();

    wait_for_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_status.size() != 0) mismatch_count++;

    $display("%0d events sent, %0d status words checked, %0d mismatches",
             items_sent, results_checked, mismatch_count);
    $display("covered directed mode paths and %0d register settings with random streams",
             phases_run);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
